>>> hdl/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared sizes, codes and control types of the positional list.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int WX_W  = (WORD_WIDTH > VALUE_W) ? WORD_WIDTH : VALUE_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_APPEND = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // operation decided for the current word
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             clr;
    logic             rd;
    logic [CMP_W-1:0] point;
  } op_t;

  // per-cell move control
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
    logic clr;
  } cell_ctl_t;

endpackage

>>> hdl/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word, loads a new one, takes a neighbor's or clears.
// ----------------------------------------------------------------------------
module pidl_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pidl_pkg::cell_ctl_t                  ctl,
  input  logic [pidl_pkg::WORD_WIDTH-1:0]      left,
  input  logic [pidl_pkg::WORD_WIDTH-1:0]      right,
  input  logic [pidl_pkg::WORD_WIDTH-1:0]      load_word,
  output logic [pidl_pkg::WORD_WIDTH-1:0]      word
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      word <= '0;
    end else if (ctl.load) begin
      word <= load_word;
    end else if (ctl.take_left) begin
      word <= left;
    end else if (ctl.take_right) begin
      word <= right;
    end
  end

endmodule

>>> hdl/pidl_ctrl.sv
// ----------------------------------------------------------------------------
// pidl_ctrl
// Length and capacity registers, request decode and status.
// ----------------------------------------------------------------------------
module pidl_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              acc,
  input  logic [pidl_pkg::MODE_W-1:0]       mode,
  input  logic [pidl_pkg::POS_W-1:0]        position,
  input  logic                              cfg_we,
  input  logic [pidl_pkg::CAP_W-1:0]        cfg_data,
  output pidl_pkg::op_t                     op,
  output logic [pidl_pkg::STATUS_W-1:0]     status,
  output logic [pidl_pkg::LEN_W-1:0]        len_next
);

  logic [pidl_pkg::LEN_W-1:0]  len;
  logic [pidl_pkg::CAP_W-1:0]  cap;
  logic [pidl_pkg::CMP_W-1:0]  pos_x;
  logic [pidl_pkg::CMP_W-1:0]  len_x;
  logic [pidl_pkg::CMP_W-1:0]  cap_x;
  logic [pidl_pkg::CMP_W-1:0]  dep_x;
  logic [pidl_pkg::CMP_W-1:0]  lim;
  logic                        ins_ok;
  logic                        del_ok;
  logic                        clr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= pidl_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (acc) begin
      len <= len_next;
    end
  end

  always_comb begin
    pos_x    = pidl_pkg::CMP_W'(position);
    len_x    = pidl_pkg::CMP_W'(len);
    cap_x    = pidl_pkg::CMP_W'(cap);
    dep_x    = pidl_pkg::CMP_W'(pidl_pkg::DEPTH);
    lim      = (cap_x > dep_x) ? dep_x : cap_x;
    status   = pidl_pkg::ST_OK;
    len_next = len;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    clr_ok   = 1'b0;
    op.rd    = 1'b0;
    op.point = pos_x;
    case (mode)
      pidl_pkg::MODE_READ: begin
        if (pos_x < len_x) begin
          op.rd = 1'b1;
        end else begin
          status = pidl_pkg::ST_RANGE;
        end
      end
      pidl_pkg::MODE_INSERT, pidl_pkg::MODE_APPEND: begin
        if (mode == pidl_pkg::MODE_APPEND) begin
          op.point = len_x;
        end
        if (op.point > len_x) begin
          status = pidl_pkg::ST_RANGE;
        end else if (len_x >= lim) begin
          status = pidl_pkg::ST_FULL;
        end else begin
          ins_ok   = 1'b1;
          len_next = len + 1'b1;
        end
      end
      pidl_pkg::MODE_DELETE: begin
        if (pos_x < len_x) begin
          del_ok   = 1'b1;
          len_next = len - 1'b1;
        end else begin
          status = pidl_pkg::ST_RANGE;
        end
      end
      pidl_pkg::MODE_CLEAR: begin
        clr_ok   = 1'b1;
        len_next = '0;
      end
      default: begin
        status = pidl_pkg::ST_RANGE;
      end
    endcase
    op.ins = acc && ins_ok;
    op.del = acc && del_ok;
    op.clr = acc && clr_ok;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pidl_pkg::CMP_W'(len) <= pidl_pkg::CMP_W'(pidl_pkg::DEPTH))
    else $error("list length above store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    acc && mode == pidl_pkg::MODE_CLEAR |=> len == '0)
    else $error("clear left a nonzero length");

  a_len_idle: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(len))
    else $error("length moved without a request");

  a_one_move: assert property (@(posedge clk)
    $onehot0({op.ins, op.del, op.clr}))
    else $error("more than one list operation at once");

endmodule

>>> hdl/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered word list held in a row of cells; read, insert, append, delete
// and clear by position, bounded by a capacity register.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------
//  in      | in_valid / in_stall   | mode, position, value
//  out     | out_valid / out_stall | status, read_word, count
//  cfg     | cfg_valid / cfg_ready | capacity
//
//  One word per cycle unless stalled: cells at or past the point shift from
//  their neighbors in the same edge, so any operation finishes in the cycle
//  it is taken; the result shows in the output register in the cycle after.
//  Input is stalled only while a result waits under out_stall.
//  Synchronous reset empties the list, zeroes all cells, capacity = 64.
// ----------------------------------------------------------------------------
module positional_insert_delete_list (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pidl_pkg::MODE_W-1:0]       mode,
  input  logic [pidl_pkg::POS_W-1:0]        position,
  input  logic [pidl_pkg::VALUE_W-1:0]      value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pidl_pkg::STATUS_W-1:0]     status,
  output logic [pidl_pkg::VALUE_W-1:0]      read_word,
  output logic [pidl_pkg::COUNT_W-1:0]      count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pidl_pkg::CAP_W-1:0]        capacity
);

  logic                                acc;
  pidl_pkg::op_t                       op;
  logic [pidl_pkg::STATUS_W-1:0]       st;
  logic [pidl_pkg::LEN_W-1:0]          len_next;
  logic [pidl_pkg::WX_W-1:0]           value_x;
  logic [pidl_pkg::WORD_WIDTH-1:0]     load_word;
  logic [pidl_pkg::WORD_WIDTH-1:0]     words [pidl_pkg::DEPTH];
  logic [pidl_pkg::WORD_WIDTH-1:0]     rd_word;
  logic [pidl_pkg::WX_W-1:0]           rd_x;
  logic [pidl_pkg::CMP_W-1:0]          cnt_x;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign acc       = in_valid && !in_stall;
  assign value_x   = pidl_pkg::WX_W'(value);
  assign load_word = value_x[pidl_pkg::WORD_WIDTH-1:0];

  pidl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .mode     (mode),
    .position (position),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (capacity),
    .op       (op),
    .status   (st),
    .len_next (len_next)
  );

  for (genvar i = 0; i < pidl_pkg::DEPTH; i++) begin : g_cell
    localparam logic [pidl_pkg::CMP_W-1:0] IX = pidl_pkg::CMP_W'(i);
    pidl_pkg::cell_ctl_t              ctl;
    logic [pidl_pkg::WORD_WIDTH-1:0]  left;
    logic [pidl_pkg::WORD_WIDTH-1:0]  right;

    assign ctl.load       = op.ins && (IX == op.point);
    assign ctl.take_left  = op.ins && (IX > op.point);
    assign ctl.take_right = op.del && (IX >= op.point);
    assign ctl.clr        = op.clr;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = words[i-1];
    end
    if (i == pidl_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = words[i+1];
    end

    pidl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (left),
      .right     (right),
      .load_word (load_word),
      .word      (words[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < pidl_pkg::DEPTH; i++) begin
      if (op.rd && (pidl_pkg::CMP_W'(i) == op.point)) begin
        rd_word = rd_word | words[i];
      end
    end
    rd_x  = pidl_pkg::WX_W'(rd_word);
    cnt_x = pidl_pkg::CMP_W'(len_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status    <= st;
      read_word <= rd_x[pidl_pkg::VALUE_W-1:0];
      count     <= cnt_x[pidl_pkg::COUNT_W-1:0];
    end
  end

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted word produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no pending result");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    acc && st != pidl_pkg::ST_OK |=> read_word == '0)
    else $error("failed request returned a nonzero word");

endmodule
